>>> hdl/brf_pkg.sv
// Package for the byte ring FIFO: sizes, request and status codes,
// transaction payload types and controller/datapath link types.
// No dependencies.
package brf_pkg;

   localparam int SIZE      = 1024;
   localparam int MAX_BURST = 64;
   localparam int PTR_W     = $clog2(SIZE);
   localparam int DATA_W    = 8;
   localparam int REQ_W     = 3;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 10;

   localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd3;
   localparam logic [REQ_W-1:0] REQ_EMPTY   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_FILL    = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [DATA_W-1:0]  data_in;
      logic [COUNT_W-1:0] burst_count;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data_out;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill_level;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic exec_single;  // finish the accepted request with one result
      logic start_burst;  // begin a read or peek burst
      logic step;         // emit the next burst byte
   } brf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;     // output register can take a result this cycle
      logic burst_ok;     // request is a read/peek with data enough for a burst
      logic rem_one;      // the byte now being emitted ends the burst
   } brf_stat_type;

endpackage

>>> hdl/brf_datapath.sv
// Datapath of the byte ring FIFO: pointers, byte memory, burst cursor,
// mode register and result register. Uses brf_pkg; driven by brf_ctrl.
module brf_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  brf_pkg::req_payload_type req_data,
   input  logic                     csr_valid,
   input  logic                     csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output brf_pkg::rsp_payload_type rsp_data,
   input  brf_pkg::brf_cmd_type     cmd,
   output brf_pkg::brf_stat_type    stat
);

   logic [brf_pkg::DATA_W-1:0] mem [brf_pkg::SIZE];

   logic [brf_pkg::PTR_W-1:0]   rp_ff, rp_in;
   logic [brf_pkg::PTR_W-1:0]   wp_ff, wp_in;
   logic [brf_pkg::PTR_W-1:0]   pos_ff, pos_in;
   logic [brf_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic                        is_read_ff, is_read_in;
   logic                        mode_ff, mode_in;
   logic                        valid_ff, valid_in;
   brf_pkg::rsp_payload_type    out_ff, out_in;
   logic [brf_pkg::DATA_W-1:0]  rd_data_ff;

   logic [brf_pkg::PTR_W-1:0]   level_now;
   logic [brf_pkg::PTR_W-1:0]   level_next;
   logic [brf_pkg::PTR_W-1:0]   rd_addr;
   logic [brf_pkg::COUNT_W-1:0] cnt_sat;
   logic                        full;
   logic                        mem_we;
   logic                        rd_en;
   logic                        is_burst_req;
   logic [brf_pkg::STATUS_W-1:0] single_status;

   assign level_now = wp_ff - rp_ff;
   assign full      = (level_now == brf_pkg::PTR_W'(brf_pkg::SIZE - 1));
   assign cnt_sat   = (req_data.burst_count > brf_pkg::COUNT_W'(brf_pkg::MAX_BURST))
                      ? brf_pkg::COUNT_W'(brf_pkg::MAX_BURST) : req_data.burst_count;
   assign is_burst_req = (req_data.req_type == brf_pkg::REQ_READ)
                      || (req_data.req_type == brf_pkg::REQ_PEEK);

   assign stat.out_free = !valid_ff || !rsp_stall;
   assign stat.burst_ok = is_burst_req && (cnt_sat != '0)
                          && (level_now >= brf_pkg::PTR_W'(cnt_sat));
   assign stat.rem_one  = (rem_ff == brf_pkg::COUNT_W'(1));

   // pointer updates and single-result status
   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      mem_we        = 1'b0;
      single_status = brf_pkg::STAT_OK;
      if (cmd.exec_single) begin
         unique case (req_data.req_type) inside
            brf_pkg::REQ_WRITE: begin
               if (full && !mode_ff) begin
                  single_status = brf_pkg::STAT_REFUSED;
               end else begin
                  if (full) begin
                     rp_in         = rp_ff + 1'b1;
                     single_status = brf_pkg::STAT_DROPPED;
                  end
                  mem_we = 1'b1;
                  wp_in  = wp_ff + 1'b1;
               end
            end
            brf_pkg::REQ_READ, brf_pkg::REQ_PEEK: begin
               if (cnt_sat != '0) begin
                  single_status = brf_pkg::STAT_SHORT;
               end
            end
            brf_pkg::REQ_DISCARD: rp_in = rp_ff + brf_pkg::PTR_W'(req_data.burst_count);
            brf_pkg::REQ_EMPTY: begin
               rp_in = '0;
               wp_in = '0;
            end
            brf_pkg::REQ_FILL: begin
               rp_in = '0;
               wp_in = brf_pkg::PTR_W'(brf_pkg::SIZE - 1);
            end
            default: ;
         endcase
      end else if (cmd.step && is_read_ff) begin
         rp_in = rp_ff + 1'b1;
      end
   end

   assign level_next = wp_in - rp_in;

   // burst cursor: pos holds the address of the byte sitting in rd_data
   always_comb begin
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      is_read_in = is_read_ff;
      rd_en      = 1'b0;
      rd_addr    = pos_ff + 1'b1;
      if (cmd.start_burst) begin
         pos_in     = rp_ff;
         rem_in     = cnt_sat;
         is_read_in = (req_data.req_type == brf_pkg::REQ_READ);
         rd_en      = 1'b1;
         rd_addr    = rp_ff;
      end else if (cmd.step) begin
         pos_in = pos_ff + 1'b1;
         rem_in = rem_ff - 1'b1;
         rd_en  = 1'b1;
      end
   end

   // result register
   always_comb begin
      out_in   = out_ff;
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (cmd.exec_single) begin
         valid_in          = 1'b1;
         out_in.data_out   = '0;
         out_in.last       = 1'b1;
         out_in.status     = single_status;
         out_in.fill_level = brf_pkg::FILL_W'(level_next);
      end else if (cmd.step) begin
         valid_in          = 1'b1;
         out_in.data_out   = rd_data_ff;
         out_in.last       = stat.rem_one;
         out_in.status     = brf_pkg::STAT_OK;
         out_in.fill_level = brf_pkg::FILL_W'(level_next);
      end
   end

   assign mode_in = csr_valid ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff    <= '0;
         wp_ff    <= '0;
         mode_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      rem_ff     <= rem_in;
      is_read_ff <= is_read_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= req_data.data_in;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> hdl/brf_ctrl.sv
// Controller of the byte ring FIFO: accepts requests and sequences bursts.
// Uses brf_pkg; commands brf_datapath.
module brf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output brf_pkg::brf_cmd_type  cmd,
   input  brf_pkg::brf_stat_type stat
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BURST = 1'b1;

   logic state_ff, state_in;
   logic accept;

   assign req_stall = !((state_ff == ST_IDLE) && stat.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      cmd.exec_single = 1'b0;
      cmd.start_burst = 1'b0;
      cmd.step        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stat.burst_ok) begin
                  cmd.start_burst = 1'b1;
                  state_in        = ST_BURST;
               end else begin
                  cmd.exec_single = 1'b1;
               end
            end
         end
         ST_BURST: begin
            // advance one byte whenever the result register frees up
            if (stat.out_free) begin
               cmd.step = 1'b1;
               if (stat.rem_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/byte_ring_fifo_overwrite.sv
// Top level of the byte ring FIFO with overwrite or refuse on full.
// Uses brf_pkg; instantiates brf_ctrl and brf_datapath.
//
//   channel  handshake              payload
//   req      req_valid / req_stall  req_data  (req_payload_type)
//   rsp      rsp_valid / rsp_stall  rsp_data  (rsp_payload_type)
//   csr      csr_valid / csr_ready  csr_data  (overwrite_mode)
//
// Write, discard, empty, fill and refused bursts finish in the accept cycle;
// one request per cycle while results are taken. A read or peek burst of N
// bytes first primes the registered memory read, then emits one byte per
// cycle while results are taken. rsp_stall holds the result register and
// the burst cursor. Reset clears pointers, mode (to overwrite) and valid;
// the byte memory is not cleared.
module byte_ring_fifo_overwrite (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  brf_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output brf_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   brf_pkg::brf_cmd_type  cmd;
   brf_pkg::brf_stat_type stat;

   assign csr_ready = 1'b1;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   brf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

>>> test/tb_byte_ring_fifo_overwrite.sv
// Self-checking testbench for byte_ring_fifo_overwrite: directed and random requests,
// with an in-bench FIFO model that predicts every result. Uses brf_pkg for payload
// types, request and status codes.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_overwrite;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = brf_pkg::MAX_BURST + 16;
   localparam logic [brf_pkg::PTR_W-1:0] FULL_LEVEL = brf_pkg::PTR_W'(brf_pkg::SIZE - 1);

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   brf_pkg::req_payload_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   brf_pkg::rsp_payload_type rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_data  = 1'b0;

   byte_ring_fifo_overwrite dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // FIFO model state, advanced on every accepted request
   logic [brf_pkg::DATA_W-1:0] fifo_mem [brf_pkg::SIZE];
   logic [brf_pkg::PTR_W-1:0]  rd_ptr = '0;
   logic [brf_pkg::PTR_W-1:0]  wr_ptr = '0;
   logic                       cfg_overwrite = 1'b1;
   brf_pkg::rsp_payload_type   expected_rsp [$];

   // stimulus planning state, advanced as requests are queued
   logic [brf_pkg::PTR_W-1:0]  plan_rd = '0;
   logic [brf_pkg::PTR_W-1:0]  plan_wr = '0;
   logic                       plan_overwrite = 1'b1;
   bit                         plan_written [brf_pkg::SIZE];
   brf_pkg::req_payload_type   pending_req [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap    = 0;
   int  stall_left  = 0;
   int  hold_left   = 0;
   bit  hold_armed  = 0;
   bit  hold_done   = 0;
   bit  no_idle     = 0;
   bit  took;
   brf_pkg::rsp_payload_type want;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void fifo_predict(input brf_pkg::req_payload_type r);
      brf_pkg::rsp_payload_type  e;
      logic [brf_pkg::PTR_W-1:0] lvl;
      logic [brf_pkg::PTR_W-1:0] pos;
      int                        n;
      lvl = wr_ptr - rd_ptr;
      n = (r.burst_count > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : int'(r.burst_count);
      e = '0;
      e.last = 1'b1;
      case (r.req_type) inside
         brf_pkg::REQ_WRITE: begin
            if (lvl == FULL_LEVEL && !cfg_overwrite) begin
               e.status = brf_pkg::STAT_REFUSED;
            end else begin
               if (lvl == FULL_LEVEL) begin
                  rd_ptr = rd_ptr + 1'b1;
                  e.status = brf_pkg::STAT_DROPPED;
               end
               fifo_mem[wr_ptr] = r.data_in;
               wr_ptr = wr_ptr + 1'b1;
            end
         end
         brf_pkg::REQ_READ, brf_pkg::REQ_PEEK: begin
            if (n != 0 && lvl >= n) begin
               pos = rd_ptr;
               for (int i = 0; i < n; i++) begin
                  e.data_out = fifo_mem[pos];
                  pos = pos + 1'b1;
                  if (r.req_type == brf_pkg::REQ_READ) lvl = lvl - 1'b1;
                  e.last = (i == n - 1);
                  e.fill_level = lvl;
                  expected_rsp.push_back(e);
               end
               if (r.req_type == brf_pkg::REQ_READ) rd_ptr = pos;
               return;
            end
            if (n != 0) e.status = brf_pkg::STAT_SHORT;
         end
         brf_pkg::REQ_DISCARD: rd_ptr = rd_ptr + brf_pkg::PTR_W'(r.burst_count);
         brf_pkg::REQ_EMPTY: begin
            rd_ptr = '0;
            wr_ptr = '0;
         end
         brf_pkg::REQ_FILL: begin
            rd_ptr = '0;
            wr_ptr = FULL_LEVEL;
         end
         default: ;
      endcase
      e.fill_level = wr_ptr - rd_ptr;
      expected_rsp.push_back(e);
   endfunction

   function automatic logic [brf_pkg::PTR_W-1:0] plan_level();
      return plan_wr - plan_rd;
   endfunction

   // a burst is safe when it is refused or touches only bytes written before
   function automatic bit burst_safe(input logic [brf_pkg::COUNT_W-1:0] cnt);
      int                        n;
      logic [brf_pkg::PTR_W-1:0] idx;
      n = (cnt > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : int'(cnt);
      if (n == 0 || plan_level() < n) return 1;
      idx = plan_rd;
      for (int i = 0; i < n; i++) begin
         if (!plan_written[idx]) return 0;
         idx = idx + 1'b1;
      end
      return 1;
   endfunction

   function automatic void plan_push(input logic [brf_pkg::REQ_W-1:0] kind,
                                     input logic [brf_pkg::DATA_W-1:0] d,
                                     input logic [brf_pkg::COUNT_W-1:0] cnt);
      brf_pkg::req_payload_type  r;
      logic [brf_pkg::PTR_W-1:0] lvl;
      int                        n;
      r.req_type = kind;
      r.data_in = d;
      r.burst_count = cnt;
      lvl = plan_level();
      n = (cnt > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : int'(cnt);
      case (kind)
         brf_pkg::REQ_WRITE: begin
            if (lvl != FULL_LEVEL || plan_overwrite) begin
               if (lvl == FULL_LEVEL) plan_rd = plan_rd + 1'b1;
               plan_written[plan_wr] = 1'b1;
               plan_wr = plan_wr + 1'b1;
            end
         end
         brf_pkg::REQ_READ: if (n != 0 && lvl >= n) plan_rd = plan_rd + brf_pkg::PTR_W'(n);
         brf_pkg::REQ_DISCARD: plan_rd = plan_rd + brf_pkg::PTR_W'(cnt);
         brf_pkg::REQ_EMPTY: begin
            plan_rd = '0;
            plan_wr = '0;
         end
         brf_pkg::REQ_FILL: begin
            plan_rd = '0;
            plan_wr = FULL_LEVEL;
         end
         default: ;
      endcase
      pending_req.push_back(r);
   endfunction

   task automatic push_random(input int count);
      int                          made;
      int                          sel;
      int                          run;
      int                          lvl;
      logic [brf_pkg::REQ_W-1:0]   kind;
      logic [brf_pkg::COUNT_W-1:0] cnt;
      made = 0;
      while (made < count) begin
         sel = $urandom_range(0, 99);
         lvl = plan_level();
         if (sel < 40) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                              : $urandom_range(1, 8);
            if (run > count - made) run = count - made;
            repeat (run) plan_push(brf_pkg::REQ_WRITE, brf_pkg::DATA_W'($urandom),
                                   brf_pkg::COUNT_W'($urandom));
            made += run;
         end else if (sel < 70) begin
            kind = ($urandom_range(0, 3) == 0) ? brf_pkg::REQ_PEEK : brf_pkg::REQ_READ;
            if (lvl >= brf_pkg::MAX_BURST && $urandom_range(0, 3) == 0)
               cnt = brf_pkg::COUNT_W'($urandom_range(brf_pkg::MAX_BURST, 127));
            else if (lvl > 0 && $urandom_range(0, 5) != 0)
               cnt = brf_pkg::COUNT_W'($urandom_range(1, (lvl > brf_pkg::MAX_BURST)
                                                          ? brf_pkg::MAX_BURST : lvl));
            else
               cnt = brf_pkg::COUNT_W'($urandom_range(0, 127));
            // never read bytes that were not written
            if (!burst_safe(cnt)) kind = brf_pkg::REQ_WRITE;
            plan_push(kind, brf_pkg::DATA_W'($urandom), cnt);
            made++;
         end else if (sel < 78) begin
            if (lvl > 0 && $urandom_range(0, 4) != 0)
               cnt = brf_pkg::COUNT_W'($urandom_range(0, (lvl > 20) ? 20 : lvl));
            else
               cnt = brf_pkg::COUNT_W'($urandom_range(0, 127));
            plan_push(brf_pkg::REQ_DISCARD, brf_pkg::DATA_W'($urandom), cnt);
            made++;
         end else if (sel < 85) begin
            plan_push(brf_pkg::REQ_EMPTY, brf_pkg::DATA_W'($urandom),
                      brf_pkg::COUNT_W'($urandom));
            made++;
         end else if (sel < 91) begin
            plan_push(brf_pkg::REQ_FILL, brf_pkg::DATA_W'($urandom),
                      brf_pkg::COUNT_W'($urandom));
            run = $urandom_range(1, 3);
            repeat (run) plan_push(brf_pkg::REQ_WRITE, brf_pkg::DATA_W'($urandom),
                                   brf_pkg::COUNT_W'($urandom));
            made += run + 1;
            if ($urandom_range(0, 1) == 1) begin
               plan_push(brf_pkg::REQ_EMPTY, brf_pkg::DATA_W'($urandom),
                         brf_pkg::COUNT_W'($urandom));
               made++;
            end
         end else begin
            // noise: discard, empty, fill or an unused code, all fields random
            plan_push(brf_pkg::REQ_W'($urandom_range(3, 7)), brf_pkg::DATA_W'($urandom),
                      brf_pkg::COUNT_W'($urandom));
            made++;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_overwrite  = value;
      plan_overwrite = value;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            fifo_predict(req_data);
            void'(pending_req.pop_front());
            send_gap = no_idle ? 0 : idle_len();
         end
         // a stalled transaction stays on the bus unchanged
         if (took || !req_valid) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_req.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_req[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result: data=%02h last=%0d status=%0d fill=%0d",
                        $time, rsp_data.data_out, rsp_data.last, rsp_data.status,
                        rsp_data.fill_level);
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.data_out !== want.data_out || rsp_data.last !== want.last ||
                   rsp_data.status !== want.status ||
                   rsp_data.fill_level !== want.fill_level) begin
                  $write("%0t: result mismatch: expected data=%02h last=%0d status=%0d",
                         $time, want.data_out, want.last, want.status);
                  $write(" fill=%0d, got data=%02h last=%0d", want.fill_level,
                         rsp_data.data_out, rsp_data.last);
                  $display(" status=%0d fill=%0d", rsp_data.status, rsp_data.fill_level);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_armed && !hold_done) begin
            // hold off long enough for the FIFO to back up into the request side
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = no_idle ? 0 : idle_len();
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      csr_write(1'b1);
      plan_push(brf_pkg::REQ_READ, 8'h00, 7'd1);      // read from an empty FIFO
      plan_push(brf_pkg::REQ_PEEK, 8'hFF, 7'd0);      // zero-length peek
      plan_push(brf_pkg::REQ_WRITE, 8'h00, 7'h7F);
      plan_push(brf_pkg::REQ_WRITE, 8'hFF, 7'h00);
      plan_push(brf_pkg::REQ_WRITE, 8'hA5, 7'h40);
      plan_push(brf_pkg::REQ_PEEK, 8'h00, 7'd3);
      plan_push(brf_pkg::REQ_READ, 8'h00, 7'd127);    // saturates, still short of data
      plan_push(brf_pkg::REQ_READ, 8'h00, 7'd2);
      plan_push(brf_pkg::REQ_READ, 8'h00, 7'd1);
      plan_push(brf_pkg::REQ_DISCARD, 8'h00, 7'd0);
      plan_push(brf_pkg::REQ_FILL, 8'h00, 7'd0);
      plan_push(brf_pkg::REQ_WRITE, 8'h3C, 7'd0);     // full: drop the oldest byte
      plan_push(brf_pkg::REQ_WRITE, 8'hC3, 7'd0);
      plan_push(brf_pkg::REQ_EMPTY, 8'h00, 7'd0);
      plan_push(brf_pkg::REQ_W'(6), 8'h5A, 7'h55);    // unused request codes
      plan_push(brf_pkg::REQ_W'(7), 8'hFF, 7'h7F);
      plan_push(brf_pkg::REQ_DISCARD, 8'h00, 7'd5);   // discard past the stored data
      plan_push(brf_pkg::REQ_EMPTY, 8'h00, 7'd0);
      plan_push(brf_pkg::REQ_READ, 8'h00, 7'd0);
      wait_idle();

      csr_write(1'b0);
      plan_push(brf_pkg::REQ_FILL, 8'h00, 7'd0);
      plan_push(brf_pkg::REQ_WRITE, 8'h81, 7'd0);     // full: refuse the byte
      plan_push(brf_pkg::REQ_WRITE, 8'h7E, 7'd0);
      plan_push(brf_pkg::REQ_EMPTY, 8'h00, 7'd0);
      plan_push(brf_pkg::REQ_WRITE, 8'h55, 7'd0);
      plan_push(brf_pkg::REQ_WRITE, 8'hAA, 7'd0);
      plan_push(brf_pkg::REQ_READ, 8'h00, 7'd2);
      wait_idle();

      csr_write(1'b1);
      push_random(18);
      wait_idle();

      csr_write(1'b0);
      push_random(18);
      hold_armed = 1'b1;
      wait_idle();

      csr_write(1'b1);
      no_idle = 1'b1;
      push_random(18);
      wait_idle();

      no_idle = 1'b0;
      csr_write(1'($urandom_range(0, 1)));
      push_random(18);
      wait_idle();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
